// File: sv/arsl_pkg.sv
`default_nettype none

package arsl_pkg;

  // Operation codes carried in the func field of a request.
  typedef enum logic [1:0] {
    FUNC_LOAD = 2'd0,
    FUNC_FIND = 2'd1,
    FUNC_READ = 2'd2,
    FUNC_BAD  = 2'd3
  } func_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_UNAVAIL  = 2'd1,
    ST_NOTFOUND = 2'd2
  } status_t;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 2;
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_HEADER_MAGIC    = 2'd0,
    REG_EXPECTED_MAGIC  = 2'd1,
    REG_HEADER_CHECKSUM = 2'd2,
    REG_ENTRY_COUNT     = 2'd3
  } cfg_reg_t;

  // The table is unusable once the entry count reaches this limit.
  localparam logic [20:0] COUNT_LIMIT = 21'(1 << 20);

  // One request beat.
  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  entry_index;
    logic [31:0] entry_base;
    logic [31:0] entry_length;
    logic [31:0] lookup_address;
  } arsl_in_t;

  // One result beat.
  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  match_index;
    logic [31:0] out_base;
    logic [31:0] out_length;
  } arsl_out_t;

  // Token handed from cell to cell. The key holds the load base or the
  // lookup address, and on a read it picks up the entry base; val holds
  // the load length, and on a read it picks up the entry length.
  typedef struct packed {
    logic        valid;
    func_t       func;
    logic [7:0]  idx;
    logic [31:0] key;
    logic [31:0] val;
    logic        done;
    status_t     status;
    logic [7:0]  match;
  } arsl_tok_t;

endpackage

`default_nettype wire

// File: sv/arsl_cell.sv
`default_nettype none

module arsl_cell #(
  parameter int CELL_INDEX = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [8:0]         entry_count,
  input  arsl_pkg::arsl_tok_t tok_in,
  output arsl_pkg::arsl_tok_t tok_out
);
  import arsl_pkg::*;

  localparam logic [31:0] CELL_WORD = 32'(CELL_INDEX);
  localparam bit SLOT_REACHABLE = (CELL_INDEX < 256);

  logic [31:0] base;
  logic [31:0] length;
  logic [31:0] range_end;
  logic        active;
  logic        slot_hit;
  logic        in_range;
  logic        write_en;
  arsl_tok_t   tok_next;

  // This cell holds an entry in use when the count reaches past it.
  assign active    = {23'b0, entry_count} > CELL_WORD;
  assign slot_hit  = SLOT_REACHABLE && (tok_in.idx == CELL_WORD[7:0]);
  assign write_en  = tok_in.valid && (tok_in.func == FUNC_LOAD) && slot_hit;
  assign range_end = base + length;
  assign in_range  = (tok_in.key >= base) && (tok_in.key < range_end);

  // Work on the passing token with this cell's entry.
  always_comb begin
    tok_next = tok_in;
    if (tok_in.valid && !tok_in.done && active) begin
      case (tok_in.func)
        FUNC_FIND: begin
          if (in_range) begin
            tok_next.status = ST_OK;
            tok_next.match  = CELL_WORD[7:0];
            tok_next.done   = 1'b1;
          end else if (tok_in.key < base) begin
            tok_next.done = 1'b1;
          end
        end
        FUNC_READ: begin
          if (slot_hit) begin
            tok_next.status = ST_OK;
            tok_next.key    = base;
            tok_next.val    = length;
            tok_next.done   = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Token stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_next.valid;
    end
    tok_out.func   <= tok_next.func;
    tok_out.idx    <= tok_next.idx;
    tok_out.key    <= tok_next.key;
    tok_out.val    <= tok_next.val;
    tok_out.done   <= tok_next.done;
    tok_out.status <= tok_next.status;
    tok_out.match  <= tok_next.match;
  end

  // Entry storage, written by a load beat that names this slot.
  always_ff @(posedge clk) begin
    if (write_en) begin
      base   <= tok_in.key;
      length <= tok_in.val;
    end
  end

endmodule

`default_nettype wire

// File: sv/address_range_symbol_lookup.sv
`default_nettype none

// Address range symbol lookup.
// A request beat is taken at a clock edge with start high and busy low; its
// func selects load entry, find address or read entry. The table lives in a
// row of TABLE_DEPTH cells, each holding one base/length entry. A request
// enters the first cell as a token and moves one cell per cycle; a find
// settles at the first entry holding the address or the first base above
// it, a read at the cell of its index, a load writes the cell of its index.
// The result is on the result port for one cycle, marked by result_strobe,
// once the token has passed the last cell, whatever func was. busy stays
// high from the accepting edge through the strobe cycle, so a new request
// is not taken until the result of the last one is out.
// The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is
// always ready and is to be written only while busy is low.
// Reset clears the registers, busy and the tokens in flight; the entries
// themselves are not cleared and must be loaded before they are used.
// The receiver cannot stall: each result beat is taken in its strobe cycle.
module address_range_symbol_lookup #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  arsl_pkg::arsl_in_t                request,
  output logic                              result_strobe,
  output arsl_pkg::arsl_out_t               result,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [arsl_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [31:0]                       cfg_data
);
  import arsl_pkg::*;

  logic [31:0] header_magic;
  logic [31:0] expected_magic;
  logic [31:0] header_checksum;
  logic [8:0]  entry_count;
  logic        accept;
  logic        usable;
  logic        slot_exists;
  arsl_tok_t   head;
  arsl_tok_t   chain [0:TABLE_DEPTH];
  arsl_tok_t   last;
  logic [TABLE_DEPTH-1:0] tok_valid;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      header_magic    <= '0;
      expected_magic  <= '0;
      header_checksum <= '0;
      entry_count     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_HEADER_MAGIC:    header_magic    <= cfg_data;
        REG_EXPECTED_MAGIC:  expected_magic  <= cfg_data;
        REG_HEADER_CHECKSUM: header_checksum <= cfg_data;
        REG_ENTRY_COUNT:     entry_count     <= cfg_data[8:0];
        default: begin
        end
      endcase
    end
  end

  // Availability is judged from the registers as each request enters.
  assign usable = (header_magic == expected_magic) &&
                  ({12'b0, entry_count} < COUNT_LIMIT) &&
                  (header_checksum == 32'd0);
  assign slot_exists = {24'b0, request.entry_index} < 32'(TABLE_DEPTH);

  // Build the token that enters the first cell.
  always_comb begin
    head.valid  = accept;
    head.func   = func_t'(request.func);
    head.idx    = request.entry_index;
    head.key    = request.lookup_address;
    head.val    = request.entry_length;
    head.done   = 1'b1;
    head.status = ST_NOTFOUND;
    head.match  = 8'd0;
    case (func_t'(request.func))
      FUNC_LOAD: begin
        head.key    = request.entry_base;
        head.status = slot_exists ? ST_OK : ST_NOTFOUND;
      end
      FUNC_FIND, FUNC_READ: begin
        head.status = usable ? ST_NOTFOUND : ST_UNAVAIL;
        head.done   = !usable;
      end
      default: begin
      end
    endcase
  end

  assign chain[0] = head;

  // The row of table cells.
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    arsl_cell #(
      .CELL_INDEX (i)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .entry_count (entry_count),
      .tok_in      (chain[i]),
      .tok_out     (chain[i+1])
    );
    assign tok_valid[i] = chain[i+1].valid;
  end

  // Shape the result beat from the token leaving the last cell.
  assign last          = chain[TABLE_DEPTH];
  assign result_strobe = last.valid;
  always_comb begin
    result.status      = last.status;
    result.match_index = '0;
    result.out_base    = '0;
    result.out_length  = '0;
    if (last.status == ST_OK) begin
      case (last.func)
        FUNC_FIND: begin
          result.match_index = last.match;
        end
        FUNC_READ: begin
          result.out_base   = last.key;
          result.out_length = last.val;
        end
        default: begin
        end
      endcase
    end
  end

  // One request in flight at a time.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept) begin
      busy <= 1'b1;
    end else if (result_strobe) begin
      busy <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0(tok_valid))
    else $error("more than one token in the cell row");

  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> busy)
    else $error("result strobe without a request in flight");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("busy not raised after an accepted beat");

  a_idle_after_result: assert property (@(posedge clk) disable iff (rst)
    result_strobe |=> !busy && !result_strobe)
    else $error("busy held after the result beat");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> (result.status == ST_OK) || (result.status == ST_UNAVAIL) ||
                      (result.status == ST_NOTFOUND))
    else $error("result status code out of range");
`endif

endmodule

`default_nettype wire

// File: tb/lookup_checker.sv
`timescale 1ns / 100ps

// Watches the request, result and register channels of the range lookup block.
// It keeps its own copy of the table and the registers, works out the answer
// to every accepted request beat and compares each result beat with the oldest
// answer still owed.
module lookup_checker #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic                             busy,
  input  arsl_pkg::arsl_in_t               request,
  input  logic                             result_strobe,
  input  arsl_pkg::arsl_out_t              result,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [arsl_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]                      cfg_data,
  output int                               pending_answers,
  output int                               mismatches
);
  import arsl_pkg::*;

  logic [31:0] tbl_base [TABLE_DEPTH];
  logic [31:0] tbl_length [TABLE_DEPTH];
  logic [31:0] hdr_magic = '0;
  logic [31:0] want_magic = '0;
  logic [31:0] hdr_checksum = '0;
  logic [8:0]  n_entries = '0;
  arsl_out_t   answers_owed [$];
  int          fail_count = 0;

  // The header decides on every request whether find and read may use the table.
  function automatic bit table_ready();
    return (hdr_magic == want_magic) && ({12'd0, n_entries} < COUNT_LIMIT) &&
           (hdr_checksum == 32'd0);
  endfunction

  // Entries a find may visit: the entry count, capped at the table depth.
  function automatic int scan_span();
    return (int'(n_entries) < TABLE_DEPTH) ? int'(n_entries) : TABLE_DEPTH;
  endfunction

  // Answer owed for one request beat. A load also updates the table copy.
  function automatic arsl_out_t lookup_answer(arsl_in_t req);
    arsl_out_t   ans;
    logic [31:0] range_end;
    ans = '0;
    ans.status = ST_NOTFOUND;
    case (func_t'(req.func))
      FUNC_LOAD: begin
        if (int'(req.entry_index) < TABLE_DEPTH) begin
          tbl_base[req.entry_index] = req.entry_base;
          tbl_length[req.entry_index] = req.entry_length;
          ans.status = ST_OK;
        end
      end
      FUNC_FIND: begin
        if (!table_ready()) begin
          ans.status = ST_UNAVAIL;
        end else begin
          // First range holding the address wins; a base above it ends the scan.
          for (int i = 0; i < scan_span(); i++) begin
            range_end = tbl_base[i] + tbl_length[i];
            if (req.lookup_address >= tbl_base[i] && req.lookup_address < range_end) begin
              ans.status = ST_OK;
              ans.match_index = 8'(i);
              break;
            end
            if (req.lookup_address < tbl_base[i]) break;
          end
        end
      end
      FUNC_READ: begin
        if (!table_ready()) begin
          ans.status = ST_UNAVAIL;
        end else if (int'(req.entry_index) < scan_span()) begin
          ans.status = ST_OK;
          ans.out_base = tbl_base[req.entry_index];
          ans.out_length = tbl_length[req.entry_index];
        end
      end
      default: begin
        ans.status = ST_NOTFOUND;
      end
    endcase
    return ans;
  endfunction

  task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    arsl_out_t due;
    if (rst) begin
      hdr_magic = '0;
      want_magic = '0;
      hdr_checksum = '0;
      n_entries = '0;
      answers_owed.delete();
    end else begin
      // Register writes only come while the block is idle, so they go first.
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_HEADER_MAGIC:    hdr_magic = cfg_data;
          REG_EXPECTED_MAGIC:  want_magic = cfg_data;
          REG_HEADER_CHECKSUM: hdr_checksum = cfg_data;
          REG_ENTRY_COUNT:     n_entries = cfg_data[8:0];
          default: begin
          end
        endcase
      end
      if (start && !busy) answers_owed.push_back(lookup_answer(request));
      // Each result beat settles the oldest answer owed.
      if (result_strobe) begin
        if (answers_owed.size() == 0) begin
          $display("%0t: result beat with no request waiting: expected none, actual %h",
                   $time, result);
          fail_count++;
        end else begin
          due = answers_owed.pop_front();
          check_field("status", 32'(due.status), 32'(result.status));
          check_field("match_index", 32'(due.match_index), 32'(result.match_index));
          check_field("out_base", due.out_base, result.out_base);
          check_field("out_length", due.out_length, result.out_length);
        end
      end
    end
    pending_answers <= answers_owed.size();
    mismatches <= fail_count;
  end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import arsl_pkg::*;

  localparam int TABLE_DEPTH = 256;
  localparam int ITEM_TARGET = 600;
  localparam int QUIET_TAIL  = 60;
  localparam int CYCLE_LIMIT = 1_000_000;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  arsl_in_t               request = '0;
  logic                   cfg_valid = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [31:0]            cfg_data = '0;
  logic                   busy;
  logic                   result_strobe;
  logic                   cfg_ready;
  arsl_out_t              result;
  int                     pending_answers;
  int                     mismatches;
  int                     cycle_count = 0;
  int                     items_sent = 0;
  bit                     pauses_on = 1'b0;
  bit                     full_table_done = 1'b0;

  // What the stimulus has loaded, used to aim finds and to keep every slot
  // that a find or read can reach written beforehand.
  bit          slot_loaded [TABLE_DEPTH];
  logic [31:0] slot_base [TABLE_DEPTH];
  logic [31:0] slot_length [TABLE_DEPTH];

  address_range_symbol_lookup #(.TABLE_DEPTH(TABLE_DEPTH)) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .result_strobe(result_strobe),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  lookup_checker #(.TABLE_DEPTH(TABLE_DEPTH)) answer_check (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .result_strobe(result_strobe),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .pending_answers(pending_answers),
    .mismatches(mismatches)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Guard against a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("address_range_symbol_lookup test failed");
      $finish;
    end
  end

  // Presents one request beat and returns at the edge that accepts it. With
  // pauses on, start sometimes drops until the block has sat idle.
  task automatic send_beat(func_t f, logic [7:0] idx, logic [31:0] base,
                           logic [31:0] len, logic [31:0] addr);
    arsl_in_t beat;
    beat.func = f;
    beat.entry_index = idx;
    beat.entry_base = base;
    beat.entry_length = len;
    beat.lookup_address = addr;
    if (pauses_on && items_sent < ITEM_TARGET - QUIET_TAIL && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      do @(posedge clk); while (busy);
      repeat ($urandom_range(0, 9)) @(posedge clk);
    end
    start <= 1'b1;
    request <= beat;
    do @(posedge clk); while (busy);
    items_sent++;
    if (f == FUNC_LOAD) begin
      slot_loaded[idx] = 1'b1;
      slot_base[idx] = base;
      slot_length[idx] = len;
    end
  endtask

  // Waits until the block is idle and every answer has come back.
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (busy || pending_answers != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t r, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Rewrites the whole header once the block has gone quiet.
  task automatic set_regs(logic [31:0] magic, logic [31:0] want, logic [31:0] checksum,
                          logic [31:0] count);
    settle();
    write_reg(REG_HEADER_MAGIC, magic);
    write_reg(REG_EXPECTED_MAGIC, want);
    write_reg(REG_HEADER_CHECKSUM, checksum);
    write_reg(REG_ENTRY_COUNT, count);
  endtask

  function automatic logic [31:0] pick_magic();
    case ($urandom_range(0, 3))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // Number of slots written without a hole, counting from slot 0.
  function automatic int loaded_prefix();
    int k;
    k = 0;
    while (k < TABLE_DEPTH && slot_loaded[k]) k++;
    return k;
  endfunction

  // Address for a find: mostly in, at or just outside one of the first n ranges.
  function automatic logic [31:0] aim_address(int n);
    int j;
    j = $urandom_range(0, n - 1);
    case ($urandom_range(0, 9))
      0: return slot_base[j];
      1: return slot_base[j] + slot_length[j] - 32'd1;
      2: return slot_base[j] + slot_length[j];
      3: return slot_base[j] - 32'd1;
      4: return $urandom();
      5: return $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
      default: begin
        if (slot_length[j] == 32'd0) return slot_base[j];
        return slot_base[j] + ($urandom() % slot_length[j]);
      end
    endcase
  endfunction

  // Loads slots 0..n-1 with ranges sorted by base: equal bases, empty ranges,
  // overlaps and ranges running past the top of the address space.
  task automatic load_sorted_table(int n);
    logic [31:0] cursor;
    logic [31:0] step_max;
    logic [31:0] base;
    logic [31:0] len;
    case ($urandom_range(0, 3))
      0: cursor = 32'h0;
      1: cursor = (n > 16) ? 32'h0 : 32'hFFFF_FF00;
      default: cursor = $urandom_range(0, 32'h7FFF_FFFF);
    endcase
    step_max = (32'hFFFF_FFFF - cursor) / (n + 1);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 5))
        0: base = cursor;
        1: base = cursor + $urandom_range(1, 16);
        default: base = cursor + $urandom_range(0, step_max);
      endcase
      cursor = base;
      case ($urandom_range(0, 7))
        0: len = 32'h0;
        1: len = 32'h1;
        2, 3: len = $urandom_range(1, step_max + 1);
        4: len = step_max * 3;
        5: len = 32'hFFFF_FFFF - base + $urandom_range(1, 64);
        6: len = $urandom();
        default: len = $urandom_range(1, 16);
      endcase
      send_beat(FUNC_LOAD, 8'(i), base, len, $urandom());
    end
  endtask

  // Finds and reads against a table whose first n slots are loaded.
  task automatic run_queries(int n, int count);
    int hi;
    hi = (n + 1 > 255) ? 255 : n + 1;
    for (int q = 0; q < count; q++) begin
      if ($urandom_range(0, 3) == 0) begin
        send_beat(FUNC_READ,
                  ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                              : 8'($urandom_range(0, hi)),
                  $urandom(), $urandom(), $urandom());
      end else begin
        send_beat(FUNC_FIND, 8'($urandom_range(0, 255)), $urandom(), $urandom(),
                  aim_address(n));
      end
    end
  endtask

  initial begin
    int n;
    int top;
    logic [31:0] m;
    logic [31:0] x;
    logic [31:0] ck;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Right after reset the table is usable but holds no entries.
    send_beat(FUNC_FIND, 8'h00, 32'h0, 32'h0, 32'h0);
    send_beat(FUNC_READ, 8'h00, 32'h0, 32'h0, 32'h0);
    send_beat(FUNC_BAD, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_beat(FUNC_LOAD, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

    // Small sorted table: an empty range, two ranges on one base and a range
    // whose end wraps past the top and so holds nothing.
    send_beat(FUNC_LOAD, 8'd0, 32'h0, 32'h0, 32'h0);
    send_beat(FUNC_LOAD, 8'd1, 32'h1000, 32'h100, 32'h0);
    send_beat(FUNC_LOAD, 8'd2, 32'h1000, 32'h2000, 32'h0);
    send_beat(FUNC_LOAD, 8'd3, 32'hFFFF_FF00, 32'h200, 32'h0);
    set_regs(32'h0, 32'h0, 32'h0, 32'd4);
    send_beat(FUNC_FIND, 8'd0, 32'h0, 32'h0, 32'h0);
    send_beat(FUNC_FIND, 8'd0, 32'h0, 32'h0, 32'h1000);
    send_beat(FUNC_FIND, 8'd0, 32'h0, 32'h0, 32'h10FF);
    send_beat(FUNC_FIND, 8'd0, 32'h0, 32'h0, 32'h1100);
    send_beat(FUNC_FIND, 8'd0, 32'h0, 32'h0, 32'h2FFF);
    send_beat(FUNC_FIND, 8'd0, 32'h0, 32'h0, 32'h3000);
    send_beat(FUNC_FIND, 8'd0, 32'h0, 32'h0, 32'hFFFF_FF80);
    send_beat(FUNC_READ, 8'd3, 32'h0, 32'h0, 32'h0);
    send_beat(FUNC_READ, 8'd4, 32'h0, 32'h0, 32'h0);

    // A nonzero checksum locks find and read out; load still goes through.
    set_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd4);
    send_beat(FUNC_FIND, 8'd0, 32'h0, 32'h0, 32'h1000);
    send_beat(FUNC_READ, 8'd0, 32'h0, 32'h0, 32'h0);
    send_beat(FUNC_LOAD, 8'd4, 32'h0, 32'hFFFF_FFFF, 32'h0);
    send_beat(FUNC_BAD, 8'd0, 32'h0, 32'h0, 32'h0);

    // So does a header magic that differs from the expected one.
    set_regs(32'hFFFF_FFFF, 32'h0, 32'h0, 32'd5);
    send_beat(FUNC_FIND, 8'd0, 32'h0, 32'h0, 32'h1000);
    send_beat(FUNC_READ, 8'd1, 32'h0, 32'h0, 32'h0);

    while (items_sent < ITEM_TARGET) begin
      pauses_on = ($urandom_range(0, 3) != 0);
      if (!full_table_done && items_sent >= 150) begin
        // One full table, scanned with the count at the depth and beyond it.
        m = pick_magic();
        set_regs(m, m, 32'h0, 32'd256);
        load_sorted_table(TABLE_DEPTH);
        run_queries(TABLE_DEPTH, 30);
        m = pick_magic();
        set_regs(m, m, 32'h0, $urandom_range(0, 1) ? 32'd511
                                                     : {23'($urandom_range(0, 32'h7F_FFFF)),
                                                        9'($urandom_range(257, 511))});
        run_queries(TABLE_DEPTH, 30);
        full_table_done = 1'b1;
      end else if ($urandom_range(0, 9) < 7) begin
        n = $urandom_range(1, 12);
        m = pick_magic();
        set_regs(m, m, 32'h0, n);
        load_sorted_table(n);
        run_queries(n, $urandom_range(n, 2 * n + 8));
      end else begin
        // Broken headers, or a good one with a random count, and random requests of every kind.
        case ($urandom_range(0, 2))
          0: begin
            x = $urandom();
            set_regs(x, x ^ ($urandom() | 32'h1), 32'h0, $urandom());
          end
          1: begin
            m = pick_magic();
            ck = $urandom();
            if (ck == 32'h0) ck = 32'h1;
            set_regs(m, m, ck, $urandom());
          end
          default: begin
            m = pick_magic();
            top = loaded_prefix();
            if (top >= TABLE_DEPTH) top = 511;
            set_regs(m, m, 32'h0, {23'($urandom_range(0, 32'h7F_FFFF)),
                                   9'($urandom_range(0, top))});
          end
        endcase
        repeat ($urandom_range(4, 12)) begin
          send_beat(func_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                    $urandom(), $urandom(), $urandom());
        end
      end
    end

    settle();
    repeat (TABLE_DEPTH + 8) @(posedge clk);
    if (mismatches == 0 && pending_answers == 0) begin
      $display("address_range_symbol_lookup test passed");
    end else begin
      $display("address_range_symbol_lookup test failed");
    end
    $finish;
  end

endmodule
